### rtl/core/rmts_pkg.sv
// Shared types, constants and helpers of the rate monotonic tick scheduler.
package rmts_pkg;

  // Register slots, always four, whatever number of tasks is scheduled
  localparam int SLOTS        = 4;
  localparam int VAL_W        = 16;
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;
  localparam int TASK_IDX_W   = 2;
  localparam int TICK_OUT_W   = 16;

  // Defaults of the top level parameters
  localparam int NUM_TASKS_DEF  = 4;
  localparam int TIME_WIDTH_DEF = 16;

  // Register indexes
  localparam logic [2:0] REG_PERIOD0 = 3'd0;
  localparam logic [2:0] REG_WCET0   = 3'd4;

  // Reset values of the registers
  localparam logic [VAL_W-1:0] PERIOD_RST = 16'd1;
  localparam logic [VAL_W-1:0] WCET_RST   = 16'd0;

  typedef struct packed {
    logic [SLOTS-1:0][VAL_W-1:0] period;
    logic [SLOTS-1:0][VAL_W-1:0] wcet;
  } cfg_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] running_task;
    logic                  idle;
    logic                  new_segment;
    logic [TICK_OUT_W-1:0] tick_number;
  } res_t;

  // A period of zero behaves as a period of one
  function automatic logic [VAL_W-1:0] eff_period(input logic [VAL_W-1:0] p);
    eff_period = (p == '0) ? VAL_W'(1) : p;
  endfunction

endpackage

### rtl/core/rmts_cfg_regs.sv
// Configuration register file with APB-style access: periods and budgets.
module rmts_cfg_regs import rmts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write the addressed register, keeping the low 16 bits of the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        cfg_r.period[s] <= PERIOD_RST;
        cfg_r.wcet[s]   <= WCET_RST;
      end
    end else if (wr_en) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (reg_idx == REG_PERIOD0 + 3'(s)) begin
          cfg_r.period[s] <= pwdata[VAL_W-1:0];
        end
        if (reg_idx == REG_WCET0 + 3'(s)) begin
          cfg_r.wcet[s] <= pwdata[VAL_W-1:0];
        end
      end
    end
  end

  // Return the addressed register
  always_comb begin
    if (reg_idx < REG_WCET0) begin
      prdata = CFG_DW'(cfg_r.period[reg_idx[1:0]]);
    end else begin
      prdata = CFG_DW'(cfg_r.wcet[reg_idx[1:0]]);
    end
  end

endmodule

### rtl/core/rmts_sched_core.sv
// Scheduler state and the tick step, done in one combinational pass: release, pick, charge.
module rmts_sched_core import rmts_pkg::*; #(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic restart,
  input  cfg_t cfg,
  output res_t res
);

  localparam logic [TIME_WIDTH-1:0] TICK_MAX = {TIME_WIDTH{1'b1}};

  logic [TIME_WIDTH-1:0]           tick_r, tick_nxt;
  logic [NUM_TASKS-1:0][VAL_W-1:0] phase_r, phase_nxt;
  logic [NUM_TASKS-1:0][VAL_W-1:0] budget_r, budget_nxt;
  logic [NUM_TASKS-1:0]            broken_r, broken_nxt;

  logic [TIME_WIDTH-1:0]           now;
  logic [NUM_TASKS-1:0][VAL_W-1:0] ph_v;
  logic [NUM_TASKS-1:0][VAL_W-1:0] bud_v;
  logic [NUM_TASKS-1:0]            brk_v;
  logic [NUM_TASKS-1:0]            rel;
  logic [NUM_TASKS-1:0]            sel;
  logic                            found;
  logic [VAL_W-1:0]                best_per;
  logic [TASK_IDX_W-1:0]           run_idx;
  logic                            fresh;
  logic [VAL_W:0]                  ph_inc;
  logic [31:0]                     now_ext;

  always_comb begin
    // Apply a restart: time zero, fresh budgets, intervals whole
    now = restart ? '0 : tick_r;
    for (int t = 0; t < NUM_TASKS; t++) begin
      ph_v[t]  = restart ? '0 : phase_r[t];
      bud_v[t] = restart ? cfg.wcet[t] : budget_r[t];
      brk_v[t] = restart ? 1'b0 : broken_r[t];
    end

    // Release jobs whose phase came round, after time zero
    for (int t = 0; t < NUM_TASKS; t++) begin
      rel[t] = (now != '0) && (ph_v[t] == '0);
      if (rel[t]) begin
        bud_v[t] = cfg.wcet[t];
      end
    end
    if (|rel) begin
      brk_v = '1;
    end

    // Pick the ready task with the shortest period, lowest index on ties
    found    = 1'b0;
    best_per = '0;
    run_idx  = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (bud_v[t] != '0 &&
          (!found || eff_period(cfg.period[t]) < best_per)) begin
        found    = 1'b1;
        best_per = eff_period(cfg.period[t]);
        run_idx  = TASK_IDX_W'(t);
      end
    end

    // Charge the running task one tick and advance the phases
    fresh = 1'b0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      sel[t] = found && (run_idx == TASK_IDX_W'(t));
      fresh  = fresh || (sel[t] && ((bud_v[t] == cfg.wcet[t]) || brk_v[t]));
      budget_nxt[t] = sel[t] ? bud_v[t] - VAL_W'(1) : bud_v[t];
      broken_nxt[t] = sel[t] ? 1'b0 : brk_v[t];
      ph_inc        = {1'b0, ph_v[t]} + (VAL_W+1)'(1);
      phase_nxt[t]  = (ph_inc >= {1'b0, eff_period(cfg.period[t])}) ?
                      '0 : ph_inc[VAL_W-1:0];
    end

    // Saturate the tick counter
    tick_nxt = (now != TICK_MAX) ? now + TIME_WIDTH'(1) : now;
    now_ext  = 32'(now);

    res.running_task = run_idx;
    res.idle         = !found;
    res.new_segment  = fresh;
    res.tick_number  = now_ext[TICK_OUT_W-1:0];
  end

  // Commit the state of one tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      phase_r  <= '0;
      budget_r <= '0;
      broken_r <= '0;
    end else if (step) begin
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
      budget_r <= budget_nxt;
      broken_r <= broken_nxt;
    end
  end

endmodule

### rtl/core/rate_monotonic_tick_scheduler.sv
// Top level of the rate monotonic tick scheduler: handshake, input and result registers.
//
// Each accepted input word is one scheduler tick; each tick yields exactly one result word
// naming the task that ran (or idle), whether it opens a new run interval, and the tick's
// time index. A tick is taken into an input register; once the result register is free or
// drains, the release, rate-monotonic pick and budget charge of all tasks are done in one
// pass and the state and the result register are written together, so the block sustains
// one tick per clock while the output does not stall. The rate rests on the update
// being done in one pass through the period compare chain. The user must write periods
// and budgets over the APB-style port while the block is idle; it is not enforced.
module rate_monotonic_tick_scheduler import rmts_pkg::*; #(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TASK_IDX_W-1:0] out_running_task,
  output logic                  out_idle,
  output logic                  out_new_segment,
  output logic [TICK_OUT_W-1:0] out_tick_number,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic in_vld_r;
  logic restart_r;
  logic out_vld_r;
  logic step;

  rmts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rmts_sched_core #(
    .NUM_TASKS  (NUM_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .restart (restart_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Advance the held tick whenever the result register is free or drains
  assign step     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      restart_r <= in_restart;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_running_task = res_r.running_task;
  assign out_idle         = res_r.idle;
  assign out_new_segment  = res_r.new_segment;
  assign out_tick_number  = res_r.tick_number;

  // An idle tick reports task zero and no new interval
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.idle |-> res_r.running_task == '0 && !res_r.new_segment)
    else $error("idle result carries a task or a new interval");

  // The input side stalls only when a word is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with no word held");

  // A processed tick always shows up as a result in the next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("processed tick produced no result");

endmodule
